[sv/cpfa_pkg.sv]
// cpfa_pkg: shared constants, types and codes for the page frame allocator
// no dependencies; used by the interfaces and by every module of the block except cpfa_ram
`timescale 1ns / 1ps
`default_nettype none

package cpfa_pkg;

  localparam int FRAME_COUNT = 64;
  localparam int PAGE_BITS   = 10;
  localparam int PROC_BITS   = 8;

  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int FILL_W  = $clog2(FRAME_COUNT + 1);
  localparam int OWNER_W = PROC_BITS + PAGE_BITS;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_FAULT  = 1'b1;

  typedef logic [FRAME_W-1:0]   frame_t;
  typedef logic [PROC_BITS-1:0] proc_t;
  typedef logic [PAGE_BITS-1:0] page_t;

  typedef struct packed {
    logic   set_en;
    frame_t set_idx;
    logic   set_mod;
    logic   clr_ref_en;
    frame_t clr_ref_idx;
    logic   grant_en;
    frame_t grant_idx;
  } flag_cmd_t;

  typedef struct packed {
    frame_t granted_frame;
    logic   evicted;
    proc_t  evicted_proc;
    page_t  evicted_page;
    logic   needs_writeback;
  } result_t;

endpackage

`default_nettype wire

[sv/cpfa_if.sv]
// cpfa_in_if / cpfa_out_if: valid/ready channels for requests and grants
// depends on cpfa_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface cpfa_in_if;
  logic                  valid;
  logic                  ready;
  logic                  op;
  cpfa_pkg::frame_t      frame_index;
  logic                  is_write;
  cpfa_pkg::proc_t       proc_id;
  cpfa_pkg::page_t       page_num;

  modport source (output valid, op, frame_index, is_write, proc_id, page_num,
                  input ready);
  modport sink   (input valid, op, frame_index, is_write, proc_id, page_num,
                  output ready);
endinterface

interface cpfa_out_if;
  logic                  valid;
  logic                  ready;
  cpfa_pkg::frame_t      granted_frame;
  logic                  evicted;
  cpfa_pkg::proc_t       evicted_proc;
  cpfa_pkg::page_t       evicted_page;
  logic                  needs_writeback;

  modport source (output valid, granted_frame, evicted, evicted_proc, evicted_page,
                  needs_writeback, input ready);
  modport sink   (input valid, granted_frame, evicted, evicted_proc, evicted_page,
                  needs_writeback, output ready);
endinterface

`default_nettype wire

[sv/clock_page_frame_allocator_top.sv]
// access: no result; the input stays ready
// fault with a free frame: result goes through the done state; ready again once it enters the output register
// fault with all frames owned: the hand tests one frame per cycle, then the read and done states follow,
//   skipping referenced frames (at most the frame count); ready again after that
// reset clears the flag bits, fill count and hand; owner ram needs no clearing
`timescale 1ns / 1ps
`default_nettype none

module clock_page_frame_allocator_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cpfa_in_if.sink    in_chan,
  cpfa_out_if.source out_chan
);

  cpfa_pkg::flag_cmd_t          flag_cmd;
  cpfa_pkg::frame_t             flag_rd_idx;
  logic                         ref_bit;
  logic                         mod_bit;
  logic                         ram_we;
  cpfa_pkg::frame_t             ram_waddr;
  logic [cpfa_pkg::OWNER_W-1:0] ram_wdata;
  cpfa_pkg::frame_t             ram_raddr;
  logic [cpfa_pkg::OWNER_W-1:0] ram_rdata;

  cpfa_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .flag_cmd    (flag_cmd),
    .flag_rd_idx (flag_rd_idx),
    .ref_bit     (ref_bit),
    .mod_bit     (mod_bit),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  cpfa_flags u_flags (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (flag_cmd),
    .rd_idx  (flag_rd_idx),
    .ref_bit (ref_bit),
    .mod_bit (mod_bit)
  );

  // owner process and page per frame
  cpfa_ram #(
    .WIDTH (cpfa_pkg::OWNER_W),
    .DEPTH (cpfa_pkg::FRAME_COUNT)
  ) u_owner_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

[sv/cpfa_ram.sv]
// cpfa_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module cpfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

[sv/cpfa_flags.sv]
// cpfa_flags: per-frame referenced and modified bits
// depends on cpfa_pkg; driven by the sequencer through flag_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module cpfa_flags (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cpfa_pkg::flag_cmd_t cmd,
  input  wire cpfa_pkg::frame_t    rd_idx,
  output logic                     ref_bit,
  output logic                     mod_bit
);

  logic [cpfa_pkg::FRAME_COUNT-1:0] ref_r, ref_nxt;
  logic [cpfa_pkg::FRAME_COUNT-1:0] mod_r, mod_nxt;

  always_comb begin
    ref_nxt = ref_r;
    mod_nxt = mod_r;
    if (cmd.set_en) begin
      ref_nxt[cmd.set_idx] = 1'b1;
      if (cmd.set_mod) begin
        mod_nxt[cmd.set_idx] = 1'b1;
      end
    end
    if (cmd.clr_ref_en) begin
      ref_nxt[cmd.clr_ref_idx] = 1'b0;
    end
    if (cmd.grant_en) begin
      ref_nxt[cmd.grant_idx] = 1'b0;
      mod_nxt[cmd.grant_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= '0;
      mod_r <= '0;
    end else begin
      ref_r <= ref_nxt;
      mod_r <= mod_nxt;
    end
  end

  assign ref_bit = ref_r[rd_idx];
  assign mod_bit = mod_r[rd_idx];

endmodule

`default_nettype wire

[sv/cpfa_seq.sv]
// cpfa_seq: request handshake, fill count, clock hand sweep and result register
// depends on cpfa_pkg and cpfa_if; drives cpfa_flags and the owner ram
`timescale 1ns / 1ps
`default_nettype none

module cpfa_seq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  cpfa_in_if.sink                    in_chan,
  cpfa_out_if.source                 out_chan,
  output cpfa_pkg::flag_cmd_t        flag_cmd,
  output cpfa_pkg::frame_t           flag_rd_idx,
  input  wire logic                  ref_bit,
  input  wire logic                  mod_bit,
  output logic                       ram_we,
  output cpfa_pkg::frame_t           ram_waddr,
  output logic [cpfa_pkg::OWNER_W-1:0] ram_wdata,
  output cpfa_pkg::frame_t           ram_raddr,
  input  wire logic [cpfa_pkg::OWNER_W-1:0] ram_rdata
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [cpfa_pkg::FILL_W-1:0] fill_r, fill_nxt;
  cpfa_pkg::frame_t            hand_r, hand_nxt;
  logic                        out_valid_r, out_valid_nxt;

  cpfa_pkg::frame_t            victim_r, victim_nxt;
  logic                        vmod_r, vmod_nxt;
  cpfa_pkg::proc_t             proc_r, proc_nxt;
  cpfa_pkg::page_t             page_r, page_nxt;
  cpfa_pkg::result_t           res_r, res_nxt;
  cpfa_pkg::result_t           out_r, out_nxt;

  logic             in_acc;
  logic             full;
  logic             in_range;
  cpfa_pkg::frame_t fill_idx;
  cpfa_pkg::frame_t hand_inc;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign full          = (fill_r == cpfa_pkg::FILL_W'(cpfa_pkg::FRAME_COUNT));
  assign fill_idx      = fill_r[cpfa_pkg::FRAME_W-1:0];
  assign in_range      = cpfa_pkg::FILL_W'(in_chan.frame_index)
                         < cpfa_pkg::FILL_W'(cpfa_pkg::FRAME_COUNT);
  assign hand_inc      = (hand_r == cpfa_pkg::FRAME_W'(cpfa_pkg::FRAME_COUNT - 1))
                         ? '0 : hand_r + 1'b1;

  assign flag_rd_idx = hand_r;
  assign ram_raddr   = hand_r;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    hand_nxt      = hand_r;
    out_valid_nxt = out_valid_r;
    victim_nxt    = victim_r;
    vmod_nxt      = vmod_r;
    proc_nxt      = proc_r;
    page_nxt      = page_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    flag_cmd      = '0;
    ram_we        = 1'b0;
    ram_waddr     = fill_idx;
    ram_wdata     = {in_chan.proc_id, in_chan.page_num};

    // output register drains independently of the sequencer
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.op == cpfa_pkg::OP_ACCESS) begin
            flag_cmd.set_en  = in_range;
            flag_cmd.set_idx = in_chan.frame_index;
            flag_cmd.set_mod = in_chan.is_write;
          end else if (!full) begin
            // lowest free frame is always the fill count
            flag_cmd.grant_en  = 1'b1;
            flag_cmd.grant_idx = fill_idx;
            ram_we             = 1'b1;
            fill_nxt           = fill_r + 1'b1;
            res_nxt            = '0;
            res_nxt.granted_frame = fill_idx;
            state_nxt          = ST_DONE;
          end else begin
            proc_nxt  = in_chan.proc_id;
            page_nxt  = in_chan.page_num;
            state_nxt = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (ref_bit) begin
          flag_cmd.clr_ref_en  = 1'b1;
          flag_cmd.clr_ref_idx = hand_r;
        end else begin
          victim_nxt = hand_r;
          vmod_nxt   = mod_bit;
          state_nxt  = ST_READ;
        end
        hand_nxt = hand_inc;
      end
      ST_READ: begin
        res_nxt.granted_frame   = victim_r;
        res_nxt.evicted         = 1'b1;
        res_nxt.evicted_proc    = ram_rdata[cpfa_pkg::OWNER_W-1:cpfa_pkg::PAGE_BITS];
        res_nxt.evicted_page    = ram_rdata[cpfa_pkg::PAGE_BITS-1:0];
        res_nxt.needs_writeback = vmod_r;
        flag_cmd.grant_en       = 1'b1;
        flag_cmd.grant_idx      = victim_r;
        ram_we                  = 1'b1;
        ram_waddr               = victim_r;
        ram_wdata               = {proc_r, page_r};
        state_nxt               = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      hand_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      hand_r      <= hand_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    victim_r <= victim_nxt;
    vmod_r   <= vmod_nxt;
    proc_r   <= proc_nxt;
    page_r   <= page_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.granted_frame   = out_r.granted_frame;
  assign out_chan.evicted         = out_r.evicted;
  assign out_chan.evicted_proc    = out_r.evicted_proc;
  assign out_chan.evicted_page    = out_r.evicted_page;
  assign out_chan.needs_writeback = out_r.needs_writeback;

endmodule

`default_nettype wire
